// ----- rtl/core/priority_sorted_insert_queue_macros.svh -----
// Assertion macros for the priority sorted insert queue.
// Used by the top level; depends on nothing else.
`ifndef PRIORITY_SORTED_INSERT_QUEUE_MACROS_SVH
`define PRIORITY_SORTED_INSERT_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSIQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/psiq_pkg.sv -----
// Shared types and constants for the priority sorted insert queue.
// Used by the interfaces, the storage cell and the top level.
package psiq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int TAG_BITS_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 4;
    localparam int STATUS_BITS       = 3;
    localparam int POSITION_BITS     = 4;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LIST   = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_INSERTED = 3'd0,
        ST_INVALID  = 3'd1,
        ST_FULL     = 3'd2,
        ST_LISTED   = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    // Per-cell control, built by the top level for each position of the chain.
    typedef struct packed {
        cell_op_t op;
        logic     occupied;  // cell index is below the occupancy
        logic     at_end;    // cell index equals the occupancy
        logic     at_tail;   // cell index is the last occupied one
    } cell_ctrl_t;

endpackage

// ----- rtl/core/psiq_req_if.sv -----
// Request channel of the priority sorted insert queue.
// Depends on psiq_pkg for default widths.
interface psiq_req_if import psiq_pkg::*; #(
    parameter int TAG_BITS      = TAG_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [TAG_BITS-1:0]      entry_tag;
    logic [PRIORITY_BITS-1:0] priority_req;

    modport source (output valid, output mode, output entry_tag, output priority_req,
                    input ready);
    modport sink   (input valid, input mode, input entry_tag, input priority_req,
                    output ready);
endinterface

// ----- rtl/core/psiq_rsp_if.sv -----
// Response channel of the priority sorted insert queue.
// Depends on psiq_pkg for default widths and field sizes.
interface psiq_rsp_if import psiq_pkg::*; #(
    parameter int TAG_BITS      = TAG_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [STATUS_BITS-1:0]   status;
    logic [TAG_BITS-1:0]      out_tag;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [POSITION_BITS-1:0] out_position;
    logic                     last;

    modport source (output valid, output status, output out_tag, output out_priority,
                    output out_position, output last, input ready);
    modport sink   (input valid, input status, input out_tag, input out_priority,
                    input out_position, input last, output ready);
endinterface

// ----- rtl/core/priority_sorted_insert_queue.sv -----
// Top level of the priority sorted insert queue: control, cell chain and response register.
// Depends on psiq_pkg, psiq_req_if, psiq_rsp_if, psiq_cell and the assertion macro header.
//
// The queue keeps up to CAPACITY entries in a chain of cells, sorted by priority with the
// highest first; a new entry lands behind every entry of equal or higher priority, so equal
// priorities keep their arrival order. An insert request is decided in the cycle it is
// accepted: every cell compares its priority with the new one in parallel, the entries of
// lower priority move one cell toward the tail, and the single response (inserted, invalid
// or full) is written to the response register. Inserts therefore run at one request per
// cycle as long as the response side takes each response. A list request on n stored
// entries is accepted and then emits one entry per listing step; each step rotates the chain
// by one cell so that the head cell always holds the next entry to emit, and after n steps
// the chain is back in its original order. No request is accepted while a listing runs. A
// list request on an empty queue answers with one empty response. Entries are never
// removed; only reset empties the queue. Positions are reported in four bits.
`include "priority_sorted_insert_queue_macros.svh"

module priority_sorted_insert_queue import psiq_pkg::*; #(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int TAG_BITS      = TAG_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    psiq_req_if.sink    req,
    psiq_rsp_if.source  rsp
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t                   state_reg;
    logic [CNT_BITS-1:0]      occ_reg;
    logic [CNT_BITS-1:0]      list_idx_reg;
    logic                     rsp_valid_reg;
    status_t                  status_reg;
    logic [TAG_BITS-1:0]      out_tag_reg;
    logic [PRIORITY_BITS-1:0] out_priority_reg;
    logic [POSITION_BITS-1:0] out_position_reg;
    logic                     last_reg;

    logic                     out_free;
    logic                     accept;
    logic                     is_list;
    logic                     is_invalid;
    logic                     is_full;
    logic                     insert_ok;
    logic                     list_step;
    logic                     list_last;
    cell_op_t                 op;
    logic [POSITION_BITS-1:0] land_pos;

    logic [TAG_BITS-1:0]      tag_w   [CAPACITY];
    logic [PRIORITY_BITS-1:0] pri_w   [CAPACITY];
    logic [CAPACITY-1:0]      shift_w;
    logic [CAPACITY-1:0]      land_w;

    // The response register is free when empty or when its response is taken this cycle.
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == S_IDLE) && out_free;
    assign accept     = req.valid && req.ready;
    assign is_list    = (req.mode == MODE_LIST);
    assign is_invalid = (req.entry_tag == '0) || (req.priority_req == '0);
    assign is_full    = (occ_reg == CNT_BITS'(CAPACITY));
    assign insert_ok  = accept && !is_list && !is_invalid && !is_full;
    assign list_step  = (state_reg == S_LIST) && out_free;
    assign list_last  = (CNT_BITS'(list_idx_reg + 1'b1) == occ_reg);

    always_comb
    begin
        if (insert_ok)
            op = CELL_INSERT;
        else if (list_step)
            op = CELL_ROTATE;
        else
            op = CELL_HOLD;
    end

    // The chain of cells. Each cell sees its left and right neighbor and the head cell.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctrl_t               ctrl;
        logic [TAG_BITS-1:0]      left_tag;
        logic [PRIORITY_BITS-1:0] left_pri;
        logic                     left_shift;
        logic [TAG_BITS-1:0]      right_tag;
        logic [PRIORITY_BITS-1:0] right_pri;

        assign ctrl.op       = op;
        assign ctrl.occupied = (occ_reg > CNT_BITS'(i));
        assign ctrl.at_end   = (occ_reg == CNT_BITS'(i));
        assign ctrl.at_tail  = (occ_reg == CNT_BITS'(i + 1));

        if (i == 0)
        begin : g_first
            assign left_tag   = '0;
            assign left_pri   = '0;
            assign left_shift = 1'b0;
        end
        else
        begin : g_inner
            assign left_tag   = tag_w[i-1];
            assign left_pri   = pri_w[i-1];
            assign left_shift = shift_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_tag = tag_w[0];
            assign right_pri = pri_w[0];
        end
        else
        begin : g_mid
            assign right_tag = tag_w[i+1];
            assign right_pri = pri_w[i+1];
        end

        psiq_cell #(
            .TAG_BITS      (TAG_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_tag    (req.entry_tag),
            .new_pri    (req.priority_req),
            .left_tag   (left_tag),
            .left_pri   (left_pri),
            .left_shift (left_shift),
            .right_tag  (right_tag),
            .right_pri  (right_pri),
            .head_tag   (tag_w[0]),
            .head_pri   (pri_w[0]),
            .tag        (tag_w[i]),
            .pri        (pri_w[i]),
            .shift      (shift_w[i]),
            .land       (land_w[i])
        );
    end

    // Exactly one cell lands the new entry, so its index is the OR of the flagged indexes.
    always_comb
    begin
        land_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (land_w[i])
                land_pos = land_pos | POSITION_BITS'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            occ_reg          <= '0;
            list_idx_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
            status_reg       <= ST_INSERTED;
            out_tag_reg      <= '0;
            out_priority_reg <= '0;
            out_position_reg <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_tag_reg      <= '0;
                        out_priority_reg <= '0;
                        out_position_reg <= '0;
                        last_reg         <= 1'b1;
                        if (is_list)
                        begin
                            if (occ_reg == '0)
                            begin
                                rsp_valid_reg <= 1'b1;
                                status_reg    <= ST_EMPTY;
                            end
                            else
                            begin
                                // The first entry is emitted by the next listing step.
                                rsp_valid_reg <= 1'b0;
                                state_reg     <= S_LIST;
                                list_idx_reg  <= '0;
                            end
                        end
                        else if (is_invalid)
                        begin
                            rsp_valid_reg <= 1'b1;
                            status_reg    <= ST_INVALID;
                        end
                        else if (is_full)
                        begin
                            rsp_valid_reg <= 1'b1;
                            status_reg    <= ST_FULL;
                        end
                        else
                        begin
                            rsp_valid_reg    <= 1'b1;
                            status_reg       <= ST_INSERTED;
                            out_position_reg <= land_pos;
                            occ_reg          <= CNT_BITS'(occ_reg + 1'b1);
                        end
                    end
                    else if (rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                end
                S_LIST:
                begin
                    // Without a step the pending response is still waiting and stays put.
                    if (list_step)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        status_reg       <= ST_LISTED;
                        out_tag_reg      <= tag_w[0];
                        out_priority_reg <= pri_w[0];
                        out_position_reg <= POSITION_BITS'(list_idx_reg);
                        last_reg         <= list_last;
                        list_idx_reg     <= CNT_BITS'(list_idx_reg + 1'b1);
                        if (list_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_tag      = out_tag_reg;
    assign rsp.out_priority = out_priority_reg;
    assign rsp.out_position = out_position_reg;
    assign rsp.last         = last_reg;

    // The occupancy never runs past the number of cells.
    `PSIQ_ASSERT_SAME(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= CNT_BITS'(CAPACITY), "occupancy above capacity")
    // An accepted insert lands in exactly one cell, and no cell lands otherwise.
    `PSIQ_ASSERT_SAME(a_land_onehot, clk, rst_n, op == CELL_INSERT, $onehot(land_w), "insert did not land in exactly one cell")
    `PSIQ_ASSERT_SAME(a_land_quiet, clk, rst_n, op != CELL_INSERT, land_w == '0, "cell landed without an insert")
    // An accepted insert grows the occupancy by one.
    `PSIQ_ASSERT_NEXT(a_occ_grow, clk, rst_n, op == CELL_INSERT, occ_reg == CNT_BITS'($past(occ_reg) + 1'b1), "occupancy did not grow on insert")
    // The final listing step returns the block to idle.
    `PSIQ_ASSERT_NEXT(a_list_end, clk, rst_n, list_step && list_last, state_reg == S_IDLE && last_reg, "listing did not end after its last entry")

endmodule

// ----- rtl/core/psiq_cell.sv -----
// One storage cell of the sorted chain: holds a tag and a priority.
// Depends on psiq_pkg for the cell control struct.
module psiq_cell import psiq_pkg::*; #(
    parameter int TAG_BITS      = TAG_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [TAG_BITS-1:0]      new_tag,
    input  logic [PRIORITY_BITS-1:0] new_pri,
    input  logic [TAG_BITS-1:0]      left_tag,
    input  logic [PRIORITY_BITS-1:0] left_pri,
    input  logic                     left_shift,
    input  logic [TAG_BITS-1:0]      right_tag,
    input  logic [PRIORITY_BITS-1:0] right_pri,
    input  logic [TAG_BITS-1:0]      head_tag,
    input  logic [PRIORITY_BITS-1:0] head_pri,
    output logic [TAG_BITS-1:0]      tag,
    output logic [PRIORITY_BITS-1:0] pri,
    output logic                     shift,
    output logic                     land
);

    logic [TAG_BITS-1:0]      tag_reg, tag_next;
    logic [PRIORITY_BITS-1:0] pri_reg, pri_next;

    // An occupied cell of strictly lower priority moves one place toward the tail.
    assign shift = ctrl.occupied && (pri_reg < new_pri);
    assign land  = (ctrl.op == CELL_INSERT) && !left_shift && (shift || ctrl.at_end);

    always_comb
    begin
        tag_next = tag_reg;
        pri_next = pri_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (left_shift)
                begin
                    tag_next = left_tag;
                    pri_next = left_pri;
                end
                else if (land)
                begin
                    tag_next = new_tag;
                    pri_next = new_pri;
                end
            end
            CELL_ROTATE:
            begin
                if (ctrl.at_tail)
                begin
                    tag_next = head_tag;
                    pri_next = head_pri;
                end
                else if (ctrl.occupied)
                begin
                    tag_next = right_tag;
                    pri_next = right_pri;
                end
            end
            default:
            begin
                tag_next = tag_reg;
                pri_next = pri_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        pri_reg <= pri_next;
    end

    assign tag = tag_reg;
    assign pri = pri_reg;

endmodule
